>>> rtl/core/csss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_pkg: shared definitions for the case-insensitive substring search
// Command codes, the decoded request type, sizing defaults and ASCII folding.
// ----------------------------------------------------------------------------
package csss_pkg;

  localparam int unsigned MaxNeedleDefault = 64;
  localparam int unsigned PosWidthDefault  = 32;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned OutPosW          = 32;

  // a-z sit at FoldBase + 1 .. FoldBase + FoldSpan; upper case is FoldDelta below
  localparam logic [ByteW-1:0] FoldBase  = 8'h60;
  localparam logic [ByteW-1:0] FoldSpan  = 8'd26;
  localparam logic [ByteW-1:0] FoldDelta = 8'd32;

  typedef enum logic {
    CmdNeedle   = 1'b0,
    CmdHaystack = 1'b1
  } cmd_e;

  // one decoded request as held in the input register
  typedef struct packed {
    logic             load;    // needle byte
    logic             search;  // haystack byte
    logic             last;
    logic [ByteW-1:0] data;
  } item_t;

  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] t;
    t = b - FoldBase;
    if (t inside {[8'd1 : FoldSpan]}) begin
      return b - FoldDelta;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/csss_needle_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_needle_store: needle byte registers and load control
// Stores folded needle bytes, tracks length and load state, flags new needles.
// ----------------------------------------------------------------------------
module csss_needle_store #(
  parameter int unsigned MAX_NEEDLE = csss_pkg::MaxNeedleDefault
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     fire_i,
  input  wire csss_pkg::item_t                          item_i,
  output logic [MAX_NEEDLE-1:0][csss_pkg::ByteW-1:0]    needle_o,
  output logic [$clog2(MAX_NEEDLE+1)-1:0]               needle_cnt_o,
  output logic                                          new_needle_o
);
  import csss_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned IdxW = $clog2(MAX_NEEDLE);

  logic [MAX_NEEDLE-1:0][ByteW-1:0] store_q;
  logic [LenW-1:0]                  len_q, len_d;
  logic                             loading_q, loading_d;
  logic                             wr_en;
  logic [IdxW-1:0]                  wr_addr;
  logic                             is_load;

  assign is_load      = fire_i && item_i.load;
  assign new_needle_o = is_load && !loading_q;

  always_comb begin
    len_d     = len_q;
    loading_d = loading_q;
    wr_en     = 1'b0;
    wr_addr   = len_q[IdxW-1:0];
    if (is_load) begin
      loading_d = !item_i.last;
      if (!loading_q) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        len_d   = LenW'(1);
      end else if (len_q < LenW'(MAX_NEEDLE)) begin
        wr_en = 1'b1;
        len_d = len_q + LenW'(1);
      end
    end else if (fire_i && item_i.search) begin
      loading_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      loading_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      loading_q <= loading_d;
    end
  end

  // bytes are kept folded; only folded values are ever compared
  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (wr_en && (wr_addr == IdxW'(k))) begin
        store_q[k] <= fold_byte(item_i.data);
      end
    end
  end

  assign needle_o     = store_q;
  assign needle_cnt_o = len_q;

endmodule
`default_nettype wire

>>> rtl/core/csss_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_match: parallel match chain and first-match tracking
// Compares each haystack byte against all needle positions at once.
// ----------------------------------------------------------------------------
module csss_match #(
  parameter int unsigned MAX_NEEDLE = csss_pkg::MaxNeedleDefault,
  parameter int unsigned POS_WIDTH  = csss_pkg::PosWidthDefault
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     fire_i,
  input  wire csss_pkg::item_t                          item_i,
  input  wire logic                                     new_needle_i,
  input  wire logic [MAX_NEEDLE-1:0][csss_pkg::ByteW-1:0] needle_i,
  input  wire logic [$clog2(MAX_NEEDLE+1)-1:0]          needle_cnt_i,
  output logic                                          res_valid_o,
  output logic                                          found_o,
  output logic [POS_WIDTH-1:0]                          position_o
);
  import csss_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned IdxW = $clog2(MAX_NEEDLE);

  logic [MAX_NEEDLE-1:0] pmv_q, pmv_new;
  logic [POS_WIDTH-1:0]  idx_q, start_q, start_new;
  logic                  seen_q;
  logic [ByteW-1:0]      fb;
  logic [LenW-1:0]       len_m1;
  logic                  hit, set_match, search, clear;

  assign fb     = fold_byte(item_i.data);
  assign len_m1 = needle_cnt_i - LenW'(1);

  // bits at or beyond the needle length stay clear
  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_chain
    if (k == 0) begin : g_head
      assign pmv_new[k] = (needle_cnt_i > LenW'(k)) && (needle_i[k] == fb);
    end else begin : g_link
      assign pmv_new[k] = (needle_cnt_i > LenW'(k)) && pmv_q[k-1] && (needle_i[k] == fb);
    end
  end

  assign hit       = (needle_cnt_i != '0) && pmv_new[len_m1[IdxW-1:0]];
  assign set_match = hit && !seen_q;
  assign start_new = idx_q - POS_WIDTH'(len_m1);
  assign search    = fire_i && item_i.search;
  assign clear     = new_needle_i || (search && item_i.last);

  assign res_valid_o = search && item_i.last;
  assign found_o     = seen_q || set_match;
  assign position_o  = seen_q ? start_q : (set_match ? start_new : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmv_q   <= '0;
      idx_q   <= '0;
      seen_q  <= 1'b0;
      start_q <= '0;
    end else if (clear) begin
      pmv_q   <= '0;
      idx_q   <= '0;
      seen_q  <= 1'b0;
      start_q <= '0;
    end else if (search) begin
      pmv_q <= pmv_new;
      if (set_match) begin
        seen_q  <= 1'b1;
        start_q <= start_new;
      end
      if (idx_q != '1) begin
        idx_q <= idx_q + POS_WIDTH'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/case_insensitive_substring_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_unit: ASCII case-insensitive search
// Loads a needle, then streams a haystack and reports the first match.
// ----------------------------------------------------------------------------
// Result path: a last haystack request passes the input register, then
//   the result register; it waits while an earlier result is not taken.
// Throughput: one request per cycle but for that wait; all needle
//   positions compare in one pass through the match chain, which feeds
//   back on itself.
// Reset: rst_ni clears length, load state, match chain, index and both
//   valid flags at once; needle bytes are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_unit #(
  parameter int unsigned MAX_NEEDLE = csss_pkg::MaxNeedleDefault,
  parameter int unsigned POS_WIDTH  = csss_pkg::PosWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          command_i,
  input  wire logic [csss_pkg::ByteW-1:0]    byte_value_i,
  input  wire logic                          last_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic [csss_pkg::OutPosW-1:0]       position_o
);
  import csss_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_NEEDLE + 1);

  // input register
  item_t s1_item_q, s1_item_d;
  logic  s1_valid_q, s1_valid_d;
  logic  s1_fire, s1_has_res, in_accept;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 found_q;
  logic [OutPosW-1:0]   position_q;

  // between units
  logic [MAX_NEEDLE-1:0][ByteW-1:0] needle;
  logic [LenW-1:0]                  needle_cnt;
  logic                             new_needle;
  logic                             res_valid, res_found;
  logic [POS_WIDTH-1:0]             res_pos;
  logic [OutPosW-1:0]               res_pos_out;

  // A request that ends a haystack may only move on when the result slot
  // is free or being drained this cycle; everything else always moves.
  assign s1_has_res = s1_item_q.search && s1_item_q.last;
  assign s1_fire    = s1_valid_q && (!s1_has_res || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    s1_item_d.load   = (command_i == CmdNeedle);
    s1_item_d.search = (command_i == CmdHaystack);
    s1_item_d.last   = last_i;
    s1_item_d.data   = byte_value_i;
  end

  assign s1_valid_d = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= s1_item_d;
    end
  end

  csss_needle_store #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .item_i       (s1_item_q),
    .needle_o     (needle),
    .needle_cnt_o (needle_cnt),
    .new_needle_o (new_needle)
  );

  csss_match #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .POS_WIDTH  (POS_WIDTH)
  ) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .item_i       (s1_item_q),
    .new_needle_i (new_needle),
    .needle_i     (needle),
    .needle_cnt_i (needle_cnt),
    .res_valid_o  (res_valid),
    .found_o      (res_found),
    .position_o   (res_pos)
  );

  // the reported position is the low bits of the internal one, or it zero-extended
  if (POS_WIDTH >= OutPosW) begin : g_pos_trunc
    assign res_pos_out = res_pos[OutPosW-1:0];
  end else begin : g_pos_ext
    assign res_pos_out = {{(OutPosW - POS_WIDTH){1'b0}}, res_pos};
  end

  assign out_valid_d = res_valid ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      found_q    <= res_found;
      position_q <= res_pos_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

`ifndef SYNTHESIS
  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a stuck input register must hold off new requests
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |-> !in_ready_o)
    else $error("request accepted while input register stalled");

  // no match reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (position_o == '0))
    else $error("nonzero position without a match");

  // needle length saturates at its capacity
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    needle_cnt <= LenW'(MAX_NEEDLE))
    else $error("needle length beyond capacity");
`endif

endmodule
`default_nettype wire
